// File: sv/eve_pkg.sv
// ----------------------------------------------------------------------------
// eve_pkg
// Shared types, widths and codes for the eased volume envelope.
// ----------------------------------------------------------------------------
package eve_pkg;

   // Fixed-point formats.
   localparam int SAMPLE_BITS     = 16;
   localparam int GAIN_FRAC_BITS  = 12;
   localparam int PHASE_FRAC_BITS = 16;
   localparam int GAIN_BITS       = 16;
   localparam int PHASE_BITS      = PHASE_FRAC_BITS + 1;
   localparam int LEN_BITS        = 24;
   localparam int COUNT_BITS      = 32;
   localparam int PROD_BITS       = SAMPLE_BITS + GAIN_BITS + 1;

   // Queue depths.
   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 8;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_LEN      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_STEP     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_START  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_LEN      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEGIN_RAMP_ON = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_RAMP_ON   = 3'd6;

   // Work kinds handed from the front to the back.
   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_HOLD = 2'd1;
   localparam logic [1:0] KIND_RAMP = 2'd2;

   // Useful fixed-point constants.
   localparam logic [PHASE_BITS-1:0] PH_ONE  = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
   localparam logic [PHASE_BITS-1:0] PH_HALF = PH_ONE >> 1;
   localparam logic [GAIN_BITS-1:0]  G_UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          stream_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          in_region;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]  target_gain;
      logic [LEN_BITS-1:0]   ramp_len;
      logic [PHASE_BITS-1:0] ramp_step;
      logic [COUNT_BITS-1:0] region_start;
      logic [COUNT_BITS-1:0] hold_len;
      logic                  begin_ramp_on;
      logic                  end_ramp_on;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [1:0]                    kind;
      logic [PHASE_BITS-1:0]         phase;
   } work_type;

endpackage

// File: sv/eve_fifo.sv
// ----------------------------------------------------------------------------
// eve_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module eve_fifo #(
   parameter int  DEPTH     = 4,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type            mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/eve_front.sv
// ----------------------------------------------------------------------------
// eve_front
// Counts sample positions, walks the envelope segments and classifies each
// item as pass, hold or ramp together with its ramp phase.
// ----------------------------------------------------------------------------
module eve_front (
   input  logic             clock,
   input  logic             reset,
   input  eve_pkg::cfg_type cfg,
   input  logic             in_valid,
   input  eve_pkg::req_type in_data,
   input  logic             work_full,
   output logic             work_push,
   output eve_pkg::work_type work_data
);
   import eve_pkg::*;

   localparam logic [2:0] SEG_BEFORE = 3'd0;
   localparam logic [2:0] SEG_RISE   = 3'd1;
   localparam logic [2:0] SEG_HOLD   = 3'd2;
   localparam logic [2:0] SEG_FALL   = 3'd3;
   localparam logic [2:0] SEG_AFTER  = 3'd4;

   logic [COUNT_BITS-1:0] position_ff, position_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [2:0]            segment_ff, segment_in;

   logic                  accept;
   logic [COUNT_BITS-1:0] pos0, cnt0, cnt1, cnt_inc, seg_len;
   logic [PHASE_BITS-1:0] ph0, ph1, ph_next;
   logic [PHASE_BITS:0]   ph_sum;
   logic [2:0]            seg0, seg1, first_seg, after_rise, after_hold, next_seg;
   logic                  rise_ok, hold_ok, fall_ok, active, done;

   assign accept    = in_valid && !work_full;
   assign work_push = accept;

   // Which segments are non-empty, and where each transition lands.
   always_comb begin
      rise_ok    = cfg.begin_ramp_on && (cfg.ramp_len != '0);
      hold_ok    = (cfg.hold_len != '0);
      fall_ok    = cfg.end_ramp_on && (cfg.ramp_len != '0);
      after_hold = fall_ok ? SEG_FALL : SEG_AFTER;
      after_rise = hold_ok ? SEG_HOLD : after_hold;
      first_seg  = rise_ok ? SEG_RISE : after_rise;
   end

   // Segment walk for the item on the input.
   always_comb begin
      // A stream start restarts the count.
      seg0 = in_data.stream_start ? SEG_BEFORE : segment_ff;
      pos0 = in_data.stream_start ? '0 : position_ff;
      cnt0 = in_data.stream_start ? '0 : count_ff;
      ph0  = in_data.stream_start ? '0 : phase_ff;

      // Enter the region once the position reaches its start.
      if (seg0 == SEG_BEFORE && pos0 >= cfg.region_start) begin
         seg1 = first_seg;
         cnt1 = '0;
         ph1  = (first_seg == SEG_FALL) ? PH_ONE : '0;
      end else begin
         seg1 = seg0;
         cnt1 = cnt0;
         ph1  = ph0;
      end

      active  = (seg1 == SEG_RISE) || (seg1 == SEG_HOLD) || (seg1 == SEG_FALL);
      cnt_inc = cnt1 + 1'b1;
      seg_len = (seg1 == SEG_HOLD) ? cfg.hold_len : COUNT_BITS'(cfg.ramp_len);
      done    = (cnt_inc >= seg_len);

      // Phase moves up on the rising ramp and down on the falling one.
      ph_sum = {1'b0, ph1} + {1'b0, cfg.ramp_step};
      if (seg1 == SEG_RISE) begin
         ph_next = (ph_sum > {1'b0, PH_ONE}) ? PH_ONE : ph_sum[PHASE_BITS-1:0];
      end else begin
         ph_next = (ph1 > cfg.ramp_step) ? ph1 - cfg.ramp_step : '0;
      end

      case (seg1)
         SEG_RISE: next_seg = after_rise;
         SEG_HOLD: next_seg = after_hold;
         default:  next_seg = SEG_AFTER;
      endcase

      if (!active) begin
         segment_in = seg1;
         count_in   = cnt1;
         phase_in   = ph1;
      end else if (done) begin
         segment_in = next_seg;
         count_in   = '0;
         phase_in   = (next_seg == SEG_FALL) ? PH_ONE : '0;
      end else begin
         segment_in = seg1;
         count_in   = cnt_inc;
         phase_in   = (seg1 == SEG_HOLD) ? ph1 : ph_next;
      end
      position_in = pos0 + 1'b1;
   end

   // Work item for the back end.
   always_comb begin
      work_data.sample = in_data.sample_in;
      work_data.phase  = ph1;
      case (seg1)
         SEG_RISE: work_data.kind = KIND_RAMP;
         SEG_FALL: work_data.kind = KIND_RAMP;
         SEG_HOLD: work_data.kind = KIND_HOLD;
         default:  work_data.kind = KIND_PASS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         count_ff    <= '0;
         phase_ff    <= '0;
         segment_ff  <= SEG_BEFORE;
      end else if (accept) begin
         position_ff <= position_in;
         count_ff    <= count_in;
         phase_ff    <= phase_in;
         segment_ff  <= segment_in;
      end
   end

endmodule

// File: sv/eve_back.sv
// ----------------------------------------------------------------------------
// eve_back
// Five-stage gain pipeline: eased curve, ramp gain, sample scaling and
// saturation, followed by the result queue.
// ----------------------------------------------------------------------------
module eve_back #(
   parameter int OUT_DEPTH = eve_pkg::OUT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  eve_pkg::cfg_type  cfg,
   input  logic              work_valid,
   input  eve_pkg::work_type work_data,
   output logic              work_pop,
   input  logic              rsp_pop,
   output eve_pkg::rsp_type  rsp_data,
   output logic              rsp_empty
);
   import eve_pkg::*;

   localparam int RES_BITS = $clog2(OUT_DEPTH + 1);
   localparam logic [PROD_BITS-1:0] SAT_POS = PROD_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic [PROD_BITS-1:0] SAT_NEG = PROD_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Results in flight plus results queued; bounds the queue so no stall is needed.
   logic [RES_BITS-1:0] reserved_ff, reserved_in;
   logic [4:0]          valid_ff, valid_in;
   logic                out_push, out_full, out_pop;

   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s2_sample_ff, s3_sample_ff;
   logic signed [SAMPLE_BITS-1:0] s4_sample_ff, s5_sample_ff;
   logic [1:0]            s1_kind_ff, s2_kind_ff, s3_kind_ff, s4_kind_ff, s5_kind_ff;
   logic                  s1_high_ff, s2_high_ff;
   logic [PHASE_BITS-1:0] s1_u_ff, s2_u_ff, s2_sq_ff, s3_ease_ff;
   logic [GAIN_BITS-1:0]  s4_gain_ff;
   logic signed [PROD_BITS-1:0] s5_prod_ff;

   logic [PHASE_BITS-1:0]   t_clip, u_in, cube, ease_in;
   logic                    high_in;
   logic [2*PHASE_BITS-1:0] sq_full, cube_full;
   logic [GAIN_BITS-1:0]    diff_mag, part, gain_in;
   logic                    diff_neg;
   logic [GAIN_BITS+PHASE_BITS-1:0] part_full;
   logic signed [PROD_BITS-1:0] prod_in;
   logic [PROD_BITS-1:0]    prod_abs, prod_mag;
   logic [SAMPLE_BITS-1:0]  y;
   rsp_type                 out_item;

   assign work_pop = work_valid && (reserved_ff < RES_BITS'(OUT_DEPTH));
   assign out_pop  = rsp_pop && !rsp_empty;
   assign out_push = valid_ff[4];
   assign valid_in = {valid_ff[3:0], work_pop};

   always_comb begin
      reserved_in = reserved_ff;
      if (work_pop && !out_pop) begin
         reserved_in = reserved_ff + 1'b1;
      end else if (out_pop && !work_pop) begin
         reserved_in = reserved_ff - 1'b1;
      end
   end

   // Stage 1: fold the phase onto one half of the curve.
   always_comb begin
      t_clip = (work_data.phase > PH_ONE) ? PH_ONE : work_data.phase;
      if (t_clip < PH_HALF) begin
         high_in = 1'b0;
         u_in    = t_clip << 1;
      end else begin
         high_in = 1'b1;
         u_in    = (PH_ONE - t_clip) << 1;
      end
   end

   // Stage 2 squares, stage 3 cubes and halves, then mirrors the upper half.
   assign sq_full   = s1_u_ff * s1_u_ff;
   assign cube_full = s2_sq_ff * s2_u_ff;
   assign cube      = cube_full[PHASE_FRAC_BITS+1 +: PHASE_BITS];
   assign ease_in   = s2_high_ff ? PH_ONE - cube : cube;

   // Stage 4: gain moves from unity toward the target along the curve; a hold uses the target.
   always_comb begin
      diff_neg  = (cfg.target_gain < G_UNITY);
      diff_mag  = diff_neg ? G_UNITY - cfg.target_gain : cfg.target_gain - G_UNITY;
      part_full = diff_mag * s3_ease_ff;
      part      = part_full[PHASE_FRAC_BITS +: GAIN_BITS];
      if (s3_kind_ff == KIND_HOLD) begin
         gain_in = cfg.target_gain;
      end else if (diff_neg) begin
         gain_in = G_UNITY - part;
      end else begin
         gain_in = G_UNITY + part;
      end
   end

   // Stage 5: scale the sample.
   assign prod_in = s4_sample_ff * $signed({1'b0, s4_gain_ff});

   // Output: truncate toward zero and saturate; pass items keep their sample.
   always_comb begin
      prod_abs = s5_prod_ff[PROD_BITS-1] ? PROD_BITS'(-s5_prod_ff) : PROD_BITS'(s5_prod_ff);
      prod_mag = prod_abs >> GAIN_FRAC_BITS;
      if (s5_prod_ff[PROD_BITS-1]) begin
         y = (prod_mag > SAT_NEG) ? SAMPLE_MIN : SAMPLE_BITS'(-prod_mag);
      end else begin
         y = (prod_mag > SAT_POS) ? SAMPLE_MAX : prod_mag[SAMPLE_BITS-1:0];
      end
      if (s5_kind_ff == KIND_PASS) begin
         out_item.sample_out = s5_sample_ff;
         out_item.in_region  = 1'b0;
      end else begin
         out_item.sample_out = $signed(y);
         out_item.in_region  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         valid_ff    <= '0;
      end else begin
         reserved_ff <= reserved_in;
         valid_ff    <= valid_in;
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      s1_sample_ff <= work_data.sample;
      s1_kind_ff   <= work_data.kind;
      s1_high_ff   <= high_in;
      s1_u_ff      <= u_in;

      s2_sample_ff <= s1_sample_ff;
      s2_kind_ff   <= s1_kind_ff;
      s2_high_ff   <= s1_high_ff;
      s2_u_ff      <= s1_u_ff;
      s2_sq_ff     <= sq_full[PHASE_FRAC_BITS +: PHASE_BITS];

      s3_sample_ff <= s2_sample_ff;
      s3_kind_ff   <= s2_kind_ff;
      s3_ease_ff   <= ease_in;

      s4_sample_ff <= s3_sample_ff;
      s4_kind_ff   <= s3_kind_ff;
      s4_gain_ff   <= gain_in;

      s5_sample_ff <= s4_sample_ff;
      s5_kind_ff   <= s4_kind_ff;
      s5_prod_ff   <= prod_in;
   end

   eve_fifo #(
      .DEPTH     (OUT_DEPTH),
      .item_type (rsp_type)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (out_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   // The reservation count keeps the queue from overflowing, so out_full is spare.
   logic unused_full;
   assign unused_full = out_full;

endmodule

// File: sv/eased_volume_envelope.sv
// ----------------------------------------------------------------------------
// eased_volume_envelope
// Audio gain envelope with cubic ease-in-out ramps and a hold at target gain.
// Throughput: one item per cycle while req_full is low; the front segment
// walk is combinational and the back gain pipeline has five register stages.
// Reset (synchronous): queues empty, envelope state before the region,
// configuration registers back to their defaults.
// ----------------------------------------------------------------------------
module eased_volume_envelope #(
   parameter int MID_DEPTH = eve_pkg::MID_DEPTH_DEF,
   parameter int OUT_DEPTH = eve_pkg::OUT_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  eve_pkg::req_type                     req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output eve_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [eve_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [eve_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import eve_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     work_push, work_full, work_valid, work_empty, work_pop;
   work_type work_in_data, work_out_data;

   assign csr_ready  = 1'b1;
   assign work_valid = !work_empty;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_GAIN:   cfg_in.target_gain   = csr_wdata[GAIN_BITS-1:0];
            CSR_RAMP_LEN:      cfg_in.ramp_len      = csr_wdata[LEN_BITS-1:0];
            CSR_RAMP_STEP:     cfg_in.ramp_step     = csr_wdata[PHASE_BITS-1:0];
            CSR_REGION_START:  cfg_in.region_start  = csr_wdata[COUNT_BITS-1:0];
            CSR_HOLD_LEN:      cfg_in.hold_len      = csr_wdata[COUNT_BITS-1:0];
            CSR_BEGIN_RAMP_ON: cfg_in.begin_ramp_on = csr_wdata[0];
            CSR_END_RAMP_ON:   cfg_in.end_ramp_on   = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_gain   <= G_UNITY;
         cfg_ff.ramp_len      <= LEN_BITS'(2);
         cfg_ff.ramp_step     <= PH_ONE;
         cfg_ff.region_start  <= '0;
         cfg_ff.hold_len      <= '0;
         cfg_ff.begin_ramp_on <= 1'b0;
         cfg_ff.end_ramp_on   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   eve_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_push),
      .in_data   (req_data),
      .work_full (work_full),
      .work_push (work_push),
      .work_data (work_in_data)
   );

   // Queue between the classifier and the gain pipeline.
   eve_fifo #(
      .DEPTH     (MID_DEPTH),
      .item_type (work_type)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in_data),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_out_data),
      .empty     (work_empty)
   );

   assign req_full = work_full;

   eve_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (work_valid),
      .work_data  (work_out_data),
      .work_pop   (work_pop),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty)
   );

endmodule

// File: sv/eve_checker.sv
// ----------------------------------------------------------------------------
// eve_checker
// Port-level checks on the eased volume envelope: item accounting and reset.
// ----------------------------------------------------------------------------
module eve_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input eve_pkg::rsp_type rsp_data
);
   import eve_pkg::*;

   // Items taken but not yet delivered.
   logic [7:0] outstanding_ff, outstanding_in;
   logic       took, gave;

   assign took = req_push && !req_full;
   assign gave = rsp_pop && !rsp_empty;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (took && !gave) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (gave && !took) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A result never appears without an item behind it.
   assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff == '0) |-> rsp_empty)
      else $error("result shown with no item outstanding");

   // The input only backs up while items are inside.
   assert property (@(posedge clock) disable iff (reset)
      req_full |-> (outstanding_ff != '0))
      else $error("input full with no item outstanding");

   // A waiting result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before it was taken");

   // Reset leaves both queues empty when it is released.
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

bind eased_volume_envelope eve_checker u_eve_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eased volume envelope. A driver pushes items
// and register writes from a prebuilt list, and a monitor runs its own copy of
// the envelope on every accepted item. It checks each popped result, field by
// field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import eve_pkg::*;

   localparam int RANDOM_ITEMS  = 550;
   localparam int CALM_TAIL     = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int LIMIT_CYCLES  = 200000;

   typedef enum logic [1:0] {OP_ITEM, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct packed {
      op_kind_type                kind;
      logic                       quiet;
      req_type                    item;
      logic [CSR_INDEX_BITS-1:0]  index;
      logic [CSR_DATA_BITS-1:0]   data;
   } work_op_type;

   typedef enum logic [2:0] {
      PART_LEAD, PART_RISE, PART_HOLD, PART_FALL, PART_TAIL
   } env_part_type;

   // Clock, reset and block inputs, all known from time zero.
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_push  = 1'b0;
   req_type                   req_data  = '0;
   logic                      rsp_pop   = 1'b0;
   logic                      csr_valid = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_full;
   logic                      rsp_empty;
   rsp_type                   rsp_data;
   logic                      csr_ready;

   // Pending stimulus and the results still owed by the block.
   work_op_type pending_work[$];
   rsp_type     owed_results[$];
   int unsigned fault_count = 0;

   // Driver state.
   work_op_type op_now;
   logic        op_live     = 1'b0;
   logic        quiet_now   = 1'b1;
   int          send_gap    = 0;
   int          settle_left = 0;
   int          pop_gap     = 0;

   // Envelope copy kept by the monitor.
   cfg_type                 env_cfg;
   logic [COUNT_BITS-1:0]   env_position;
   logic [COUNT_BITS-1:0]   env_count;
   logic [PHASE_BITS-1:0]   env_phase;
   env_part_type            env_part;

   eased_volume_envelope dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Envelope arithmetic.
   // ------------------------------------------------------------------------
   function automatic longint part_len(env_part_type p);
      if (p == PART_RISE || p == PART_FALL) return longint'(env_cfg.ramp_len);
      if (p == PART_HOLD) return longint'(env_cfg.hold_len);
      return 1;
   endfunction

   function automatic env_part_type part_after(env_part_type p);
      if (p == PART_LEAD) return env_cfg.begin_ramp_on ? PART_RISE : PART_HOLD;
      if (p == PART_RISE) return PART_HOLD;
      if (p == PART_HOLD) return env_cfg.end_ramp_on ? PART_FALL : PART_TAIL;
      return PART_TAIL;
   endfunction

   // Empty or disabled parts are skipped straight away.
   function automatic void enter_part(env_part_type p);
      while (p != PART_TAIL && part_len(p) == 0) p = part_after(p);
      env_part  = p;
      env_count = '0;
      env_phase = (p == PART_FALL) ? PH_ONE : '0;
   endfunction

   function automatic longint half_cube(longint u);
      longint sq;
      sq = (u * u) >> PHASE_FRAC_BITS;
      return (sq * u) >> (PHASE_FRAC_BITS + 1);
   endfunction

   // Cubic ease-in-out of the phase, both in Q1.16.
   function automatic longint eased(longint t);
      longint one;
      one = longint'(PH_ONE);
      if (t > one) t = one;
      if (t < one / 2) return half_cube(2 * t);
      return one - half_cube(2 * one - 2 * t);
   endfunction

   function automatic longint ramp_gain(logic [PHASE_BITS-1:0] t);
      longint diff, mag, part;
      diff = longint'(env_cfg.target_gain) - longint'(G_UNITY);
      mag  = (diff < 0) ? -diff : diff;
      part = (mag * eased(longint'(t))) >> PHASE_FRAC_BITS;
      return longint'(G_UNITY) + ((diff < 0) ? -part : part);
   endfunction

   // Product truncated toward zero, then clipped to the sample range.
   function automatic longint apply_gain(longint smp, longint g);
      longint prod, mag, r, hi;
      hi   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      prod = smp * g;
      mag  = ((prod < 0) ? -prod : prod) >> GAIN_FRAC_BITS;
      r    = (prod < 0) ? -mag : mag;
      if (r > hi) r = hi;
      if (r < -hi - 1) r = -hi - 1;
      return r;
   endfunction

   // Advances the envelope by one sample and returns the result it owes.
   function automatic rsp_type predict_envelope(req_type it);
      rsp_type               r;
      longint                smp, y;
      logic [PHASE_BITS:0]   raised;
      smp = longint'(it.sample_in);
      r   = '0;
      if (it.stream_start) begin
         env_position = '0;
         env_part     = PART_LEAD;
         env_count    = '0;
         env_phase    = '0;
      end
      if (env_part == PART_LEAD && env_position >= env_cfg.region_start)
         enter_part(part_after(PART_LEAD));

      if (env_part inside {PART_RISE, PART_HOLD, PART_FALL}) begin
         r.in_region = 1'b1;
         if (env_part == PART_HOLD) begin
            y = apply_gain(smp, longint'(env_cfg.target_gain));
         end else begin
            y = apply_gain(smp, ramp_gain(env_phase));
            if (env_part == PART_RISE) begin
               raised    = env_phase + env_cfg.ramp_step;
               env_phase = (raised > PH_ONE) ? PH_ONE : raised[PHASE_BITS-1:0];
            end else begin
               env_phase = (env_phase > env_cfg.ramp_step) ?
                           env_phase - env_cfg.ramp_step : '0;
            end
         end
         env_count = env_count + 1'b1;
         if (longint'(env_count) >= part_len(env_part)) enter_part(part_after(env_part));
      end else begin
         y = smp;
      end
      env_position = env_position + 1'b1;
      r.sample_out = SAMPLE_BITS'(y);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus list building.
   // ------------------------------------------------------------------------
   task automatic queue_item(input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic start, input logic quiet);
      work_op_type op;
      op                   = '0;
      op.kind              = OP_ITEM;
      op.quiet             = quiet;
      op.item.sample_in    = smp;
      op.item.stream_start = start;
      pending_work.push_back(op);
   endtask

   // The sender holds off until every owed result has come back.
   task automatic queue_drain();
      work_op_type op;
      op      = '0;
      op.kind = OP_DRAIN;
      pending_work.push_back(op);
   endtask

   // Writes all seven registers once the block has gone idle.
   task automatic queue_settings(input logic [31:0] gain, input logic [31:0] rlen,
                                 input logic [31:0] rstep, input logic [31:0] rstart,
                                 input logic [31:0] hlen, input logic rise_on,
                                 input logic fall_on);
      work_op_type op;
      logic [31:0] vals[7];
      logic [CSR_INDEX_BITS-1:0] idx[7];
      queue_drain();
      vals = '{gain, rlen, rstep, rstart, hlen, 32'(rise_on), 32'(fall_on)};
      idx  = '{CSR_TARGET_GAIN, CSR_RAMP_LEN, CSR_RAMP_STEP, CSR_REGION_START,
               CSR_HOLD_LEN, CSR_BEGIN_RAMP_ON, CSR_END_RAMP_ON};
      for (int i = 0; i < 7; i++) begin
         op       = '0;
         op.kind  = OP_CSR;
         op.index = idx[i];
         op.data  = vals[i];
         pending_work.push_back(op);
      end
   endtask

   // Random sample leaning on the extremes now and then.
   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 11))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         2:       return 16'sd0;
         3:       return -16'sd1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int          made, n, pick;
      logic        phase_quiet, start;
      logic [31:0] gain, rlen, rstep, rstart, hlen;

      // Full rise, hold and fall at the largest gain, with extreme samples.
      queue_settings(32'hFFFF, 4, 21845, 2, 3, 1'b1, 1'b1);
      queue_item(16'sh7FFF, 1'b1, 1'b0);
      queue_item(-16'sh8000, 1'b0, 1'b0);
      queue_item(16'sh7FFF, 1'b0, 1'b0);
      queue_item(-16'sh8000, 1'b0, 1'b0);
      queue_item(16'sd1, 1'b0, 1'b0);
      queue_item(-16'sd1, 1'b0, 1'b0);
      queue_item(16'sh7FFF, 1'b0, 1'b0);
      queue_item(-16'sh8000, 1'b0, 1'b0);
      queue_item(16'sd12345, 1'b0, 1'b0);
      queue_item(-16'sh8000, 1'b0, 1'b0);
      queue_item(16'sh7FFF, 1'b0, 1'b0);
      queue_item(16'sd100, 1'b0, 1'b0);
      queue_item(-16'sd100, 1'b0, 1'b0);
      queue_item(16'sd5, 1'b0, 1'b0);

      // Zero-length ramps, zero gain and a hold that is cut short mid-way.
      queue_settings(0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1, 1'b1);
      queue_item(16'sd1000, 1'b1, 1'b0);
      queue_item(-16'sd1000, 1'b0, 1'b0);
      queue_item(16'sh7FFF, 1'b0, 1'b0);
      queue_settings(0, 0, 0, 0, 1, 1'b1, 1'b1);
      queue_item(-16'sh8000, 1'b0, 1'b0);
      queue_item(16'sd77, 1'b0, 1'b0);

      // A phase step of zero parks each ramp at its starting gain.
      queue_settings(8192, 3, 0, 0, 0, 1'b1, 1'b1);
      queue_item(16'sd20000, 1'b1, 1'b0);
      queue_item(-16'sd20000, 1'b0, 1'b0);
      queue_item(16'sd16384, 1'b0, 1'b0);
      queue_item(16'sd20000, 1'b0, 1'b0);
      queue_item(-16'sd20000, 1'b0, 1'b0);
      queue_item(-16'sd16385, 1'b0, 1'b0);

      // Random envelopes, mostly short enough that every part is reached.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         gain = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF :
                (pick == 2) ? 32'(G_UNITY) : (pick < 6) ? $urandom_range(0, 16'hFFFF) :
                $urandom_range(2048, 12288);
         pick = $urandom_range(0, 19);
         rlen = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 : (pick == 2) ? 32'hFF_FFFF :
                (pick == 3) ? ($urandom & 32'hFF_FFFF) : $urandom_range(2, 8);
         pick = $urandom_range(0, 19);
         rstep = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h1_FFFF :
                 (pick == 2) ? ($urandom & 32'h1_FFFF) : (pick == 3) ? 32'd1 :
                 (rlen >= 2) ? 32'd65536 / (rlen - 1) : 32'd65536;
         pick   = $urandom_range(0, 19);
         rstart = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? $urandom :
                  $urandom_range(0, 5);
         pick   = $urandom_range(0, 19);
         hlen   = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? $urandom :
                  $urandom_range(0, 6);
         queue_settings(gain, rlen, rstep, rstart, hlen,
                        $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
         phase_quiet = ($urandom_range(0, 3) == 0);
         n = $urandom_range(10, 30);
         for (int k = 0; k < n; k++) begin
            start = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 24) == 0);
            if (k > 0 && $urandom_range(0, 39) == 0) queue_drain();
            queue_item(rand_sample(), start,
                       phase_quiet || made >= RANDOM_ITEMS - CALM_TAIL);
            made++;
         end
      end

      // Wait for every item to go in and every result to come out.
      while (pending_work.size() != 0 || op_live) @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: works through the pending list, one operation at a time.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic finished;
      logic was_item;
      if (reset) begin
         req_push    <= 1'b0;
         csr_valid   <= 1'b0;
         op_live     = 1'b0;
         send_gap    = 0;
         settle_left = 0;
      end else begin
         finished = 1'b0;
         was_item = 1'b0;
         if (op_live) begin
            case (op_now.kind)
               OP_ITEM: finished = req_push && !req_full;
               OP_CSR:  finished = csr_valid && csr_ready;
               default: begin
                  if (owed_results.size() != 0) settle_left = SETTLE_CYCLES;
                  else if (settle_left > 0) settle_left--;
                  finished = (settle_left == 0) && (owed_results.size() == 0);
               end
            endcase
            was_item = finished && (op_now.kind == OP_ITEM);
         end

         // Load the next operation; sometimes idle a little between items.
         if (!op_live || finished) begin
            op_live = (pending_work.size() != 0);
            if (op_live) begin
               op_now      = pending_work.pop_front();
               settle_left = SETTLE_CYCLES;
               if (was_item && op_now.kind == OP_ITEM && !op_now.quiet &&
                   $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 3);
            end
         end

         req_push  <= op_live && op_now.kind == OP_ITEM && send_gap == 0;
         csr_valid <= op_live && op_now.kind == OP_CSR;
         // Drains and register writes keep the pacing of the items around them.
         if (!op_live) begin
            quiet_now <= 1'b1;
         end else if (op_now.kind == OP_ITEM) begin
            quiet_now <= op_now.quiet;
         end
         if (op_live) begin
            req_data  <= op_now.item;
            csr_index <= op_now.index;
            csr_wdata <= op_now.data;
         end
         if (send_gap > 0) send_gap--;
      end
   end

   // Result side: pop is dropped in short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else if (pop_gap > 0) begin
         rsp_pop <= 1'b0;
         pop_gap--;
      end else if (!quiet_now && $urandom_range(0, 5) == 0) begin
         rsp_pop <= 1'b0;
         pop_gap = $urandom_range(0, 2);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: tracks register writes, predicts each accepted item and checks
   // each popped result against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         env_cfg.target_gain   = G_UNITY;
         env_cfg.ramp_len      = LEN_BITS'(2);
         env_cfg.ramp_step     = PH_ONE;
         env_cfg.region_start  = '0;
         env_cfg.hold_len      = '0;
         env_cfg.begin_ramp_on = 1'b0;
         env_cfg.end_ramp_on   = 1'b0;
         env_position          = '0;
         env_count             = '0;
         env_phase             = '0;
         env_part              = PART_LEAD;
         owed_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_GAIN:   env_cfg.target_gain   = csr_wdata[GAIN_BITS-1:0];
               CSR_RAMP_LEN:      env_cfg.ramp_len      = csr_wdata[LEN_BITS-1:0];
               CSR_RAMP_STEP:     env_cfg.ramp_step     = csr_wdata[PHASE_BITS-1:0];
               CSR_REGION_START:  env_cfg.region_start  = csr_wdata[COUNT_BITS-1:0];
               CSR_HOLD_LEN:      env_cfg.hold_len      = csr_wdata[COUNT_BITS-1:0];
               CSR_BEGIN_RAMP_ON: env_cfg.begin_ramp_on = csr_wdata[0];
               CSR_END_RAMP_ON:   env_cfg.end_ramp_on   = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_push && !req_full) owed_results.push_back(predict_envelope(req_data));

         if (rsp_pop && !rsp_empty) begin
            if (owed_results.size() == 0) begin
               $error("unexpected item: sample_out %0d, in_region %0d",
                      rsp_data.sample_out, rsp_data.in_region);
               fault_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.sample_out !== want.sample_out) begin
                  $error("sample_out: expected %0d, got %0d",
                         want.sample_out, rsp_data.sample_out);
                  fault_count++;
               end
               if (rsp_data.in_region !== want.in_region) begin
                  $error("in_region: expected %0d, got %0d",
                         want.in_region, rsp_data.in_region);
                  fault_count++;
               end
            end
         end
      end
   end

endmodule

// File: files.f
sv/eve_pkg.sv
sv/eve_fifo.sv
sv/eve_front.sv
sv/eve_back.sv
sv/eased_volume_envelope.sv
sv/eve_checker.sv
tb/sv/tb_top.sv
